FILE: rtl/core/cpf_pkg.sv
`default_nettype none
package cpf_pkg;

  localparam logic [7:0]  HEAD_BYTE    = 8'hC0;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [7:0]  MAX_LEN      = 8'd15;
  localparam logic        OP_START     = 1'b0;
  localparam logic        OP_PAYLOAD   = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // One entry of work for the back end: up to four bytes, sent from index 0
  // up to last_idx; the final one carries the frame end flag if end_flag is set.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            end_flag;
  } cpf_job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cpf_front.sv
`default_nettype none
module cpf_front
  import cpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic       operation,
  input  wire logic       write_flag,
  input  wire logic       cmd_crc_enable,
  input  wire logic       data_crc_enable,
  input  wire logic [7:0] payload_length,
  input  wire logic [7:0] payload_byte,
  output logic            push,
  output cpf_job_t        job
);

  logic [15:0] crc_accum_r, crc_accum_nxt;
  logic [3:0]  bytes_left_r, bytes_left_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic        append_crc_r, append_crc_nxt;
  logic [3:0]  len_c;
  logic [7:0]  ctrl_c;
  logic [3:0]  left_dec;

  always_comb begin
    len_c    = (payload_length > MAX_LEN) ? MAX_LEN[3:0] : payload_length[3:0];
    ctrl_c   = {write_flag, cmd_crc_enable, data_crc_enable, 1'b0, len_c};
    left_dec = bytes_left_r - 4'd1;

    crc_accum_nxt  = crc_accum_r;
    bytes_left_nxt = bytes_left_r;
    frame_open_nxt = frame_open_r;
    append_crc_nxt = append_crc_r;
    push           = 1'b0;
    job            = '0;

    if (acc) begin
      if (operation == OP_START) begin
        push           = 1'b1;
        crc_accum_nxt  = crc_byte(CRC_INIT, ctrl_c);
        append_crc_nxt = cmd_crc_enable;
        bytes_left_nxt = len_c;
        frame_open_nxt = 1'b1;
        job.bytes      = {crc_accum_nxt[15:8], crc_accum_nxt[7:0], ctrl_c, HEAD_BYTE};
        job.last_idx   = 2'd1;
        job.end_flag   = 1'b0;
        if (len_c == 4'd0) begin
          frame_open_nxt = 1'b0;
          job.end_flag   = 1'b1;
          if (cmd_crc_enable) begin
            job.last_idx = 2'd3;
          end
        end
      end else if (frame_open_r) begin
        push           = 1'b1;
        crc_accum_nxt  = crc_byte(crc_accum_r, payload_byte);
        bytes_left_nxt = left_dec;
        job.bytes      = {8'h00, crc_accum_nxt[15:8], crc_accum_nxt[7:0], payload_byte};
        job.last_idx   = 2'd0;
        job.end_flag   = 1'b0;
        if (left_dec == 4'd0) begin
          frame_open_nxt = 1'b0;
          job.end_flag   = 1'b1;
          if (append_crc_r) begin
            job.last_idx = 2'd2;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_accum_r  <= CRC_INIT;
      bytes_left_r <= 4'd0;
      frame_open_r <= 1'b0;
      append_crc_r <= 1'b0;
    end else begin
      crc_accum_r  <= crc_accum_nxt;
      bytes_left_r <= bytes_left_nxt;
      frame_open_r <= frame_open_nxt;
      append_crc_r <= append_crc_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cpf_queue.sv
`default_nettype none
module cpf_queue
  import cpf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire cpf_job_t push_job,
  input  wire logic     pop,
  output logic          full,
  output logic          empty,
  output cpf_job_t      head_job
);

  cpf_job_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   count_r;

  assign full     = (count_r == Q_CW'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cpf_back.sv
`default_nettype none
module cpf_back
  import cpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire cpf_job_t   head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_frame_end
);

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       load;
  logic       at_last;

  assign load    = head_valid && (!valid_r || out_ready);
  assign at_last = (idx_r == head_job.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_job.bytes[idx_r];
      end_r  <= at_last && head_job.end_flag;
    end
  end

  assign out_valid      = valid_r;
  assign out_frame_byte = byte_r;
  assign out_frame_end  = end_r;

endmodule
`default_nettype wire

FILE: rtl/core/control_packet_framer_crc16_unit.sv
// An accepted item is written into the queue, then its first byte goes to the output byte
// register. One result byte per cycle while out_ready is high, one to four bytes per item;
// the output byte register is the limit, and a two-entry queue decouples the input.
// Reset (rst_n, synchronous, active low) empties the queue and output, sets the CRC
// to 0xFFFF and closes any open frame.
`default_nettype none
module control_packet_framer_crc16_unit
  import cpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_operation,
  input  wire logic       in_write_flag,
  input  wire logic       in_cmd_crc_enable,
  input  wire logic       in_data_crc_enable,
  input  wire logic [7:0] in_payload_length,
  input  wire logic [7:0] in_payload_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_frame_byte,
  output logic            out_frame_end
);

  logic     fr_push;
  cpf_job_t fr_job;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  cpf_job_t q_head;

  assign in_ready = !q_full;

  cpf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (in_valid && in_ready),
    .operation       (in_operation),
    .write_flag      (in_write_flag),
    .cmd_crc_enable  (in_cmd_crc_enable),
    .data_crc_enable (in_data_crc_enable),
    .payload_length  (in_payload_length),
    .payload_byte    (in_payload_byte),
    .push            (fr_push),
    .job             (fr_job)
  );

  cpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fr_push),
    .push_job (fr_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head_job (q_head)
  );

  cpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (!q_empty),
    .head_job       (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fr_push |-> !q_full)
    else $error("item pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !fr_push && q_head.end_flag && !q_full) |=> !q_full)
    else $error("queue full after draining a closing item");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import cpf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic [7:0] value;
    logic       is_end;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_operation = OP_START;
  logic       in_write_flag = 1'b0;
  logic       in_cmd_crc_enable = 1'b0;
  logic       in_data_crc_enable = 1'b0;
  logic [7:0] in_payload_length = 8'd0;
  logic [7:0] in_payload_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_frame_byte;
  logic       out_frame_end;

  control_packet_framer_crc16_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_write_flag      (in_write_flag),
    .in_cmd_crc_enable  (in_cmd_crc_enable),
    .in_data_crc_enable (in_data_crc_enable),
    .in_payload_length  (in_payload_length),
    .in_payload_byte    (in_payload_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_byte     (out_frame_byte),
    .out_frame_end      (out_frame_end)
  );

  frame_byte_t pending_bytes[$];
  frame_byte_t wanted;

  logic [15:0] crc_run = CRC_INIT;
  logic [3:0]  bytes_due = 4'd0;
  logic        frame_live = 1'b0;
  logic        trailer_due = 1'b0;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int fault_count = 0;
  int items_taken = 0;
  int bytes_seen = 0;
  int frames_seen = 0;
  int dropped_count = 0;
  int input_stalls = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d bytes outstanding.", cycle_count,
               pending_bytes.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic is_end);
    pending_bytes.push_back('{value: value, is_end: is_end});
  endtask

  task automatic close_frame(input logic [7:0] final_byte);
    if (trailer_due) begin
      push_byte(final_byte, 1'b0);
      push_byte(crc_run[7:0], 1'b0);
      push_byte(crc_run[15:8], 1'b1);
    end else begin
      push_byte(final_byte, 1'b1);
    end
    frame_live = 1'b0;
    bytes_due = 4'd0;
  endtask

  task automatic predict_frame(input logic op, input logic wf, input logic cce,
                               input logic dce, input logic [7:0] len,
                               input logic [7:0] pb);
    logic [7:0] ctrl;
    logic [3:0] count;
    if (op == OP_START) begin
      count = (len > MAX_LEN) ? MAX_LEN[3:0] : len[3:0];
      ctrl = {wf, cce, dce, 1'b0, count};
      trailer_due = cce;
      crc_run = crc16_update(CRC_INIT, ctrl);
      bytes_due = count;
      frame_live = 1'b1;
      push_byte(HEAD_BYTE, 1'b0);
      if (count == 4'd0) begin
        close_frame(ctrl);
      end else begin
        push_byte(ctrl, 1'b0);
      end
    end else if (frame_live) begin
      crc_run = crc16_update(crc_run, pb);
      bytes_due = bytes_due - 4'd1;
      if (bytes_due == 4'd0) begin
        close_frame(pb);
      end else begin
        push_byte(pb, 1'b0);
      end
    end else begin
      dropped_count++;
    end
  endtask

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (pending_bytes.size() == 0) begin
          note_fault($sformatf("Unexpected byte %02h end %0b.", out_frame_byte,
                               out_frame_end));
        end else begin
          wanted = pending_bytes.pop_front();
          if (out_frame_byte !== wanted.value || out_frame_end !== wanted.is_end) begin
            note_fault($sformatf("Byte mismatch: expected %02h end %0b, got %02h end %0b.",
                                 wanted.value, wanted.is_end, out_frame_byte,
                                 out_frame_end));
          end
        end
        if (out_frame_end === 1'b1) begin
          frames_seen++;
        end
      end
      if (in_valid && !in_ready) begin
        input_stalls++;
      end
      if (in_valid && in_ready) begin
        items_taken++;
        predict_frame(in_operation, in_write_flag, in_cmd_crc_enable, in_data_crc_enable,
                      in_payload_length, in_payload_byte);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic wf, input logic cce, input logic dce,
                           input logic [7:0] len, input logic [7:0] pb);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_write_flag <= wf;
    in_cmd_crc_enable <= cce;
    in_data_crc_enable <= dce;
    in_payload_length <= len;
    in_payload_byte <= pb;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_start(input logic wf, input logic cce, input logic dce,
                            input logic [7:0] len);
    send_item(OP_START, wf, cce, dce, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] pb);
    send_item(OP_PAYLOAD, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), pb);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic test_directed_frames;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_item(OP_PAYLOAD, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF);
    send_start(1'b0, 1'b0, 1'b0, 8'd0);
    send_start(1'b1, 1'b1, 1'b1, 8'd0);
    send_item(OP_START, 1'b1, 1'b1, 1'b1, 8'd3, 8'h5A);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'hA5);
    send_payload(8'h11);
    send_start(1'b0, 1'b1, 1'b0, 8'd255);
    send_payload(8'h01);
    send_payload(8'hFE);
    send_start(1'b1, 1'b0, 1'b1, 8'd16);
    send_payload(8'h80);
    send_start(1'b0, 1'b1, 1'b1, 8'd1);
    send_payload(8'h7F);
    send_start(1'b1, 1'b0, 1'b0, 8'd2);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_item(OP_PAYLOAD, 1'b0, 1'b0, 1'b0, 8'h00, 8'h33);
    drain();
  endtask

  task automatic test_random_traffic(input int item_goal, input int idle_pct,
                                     input int stall_pct);
    int sent;
    int pick;
    int len;
    int count;
    int given;
    logic left_open;
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    sent = 0;
    left_open = 1'b0;
    while (sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 6 && !left_open) begin
        send_payload(8'($urandom));
        sent++;
      end else begin
        len = $urandom_range(99);
        if (len < 75) begin
          len = $urandom_range(0, 4);
        end else if (len < 90) begin
          len = $urandom_range(5, 15);
        end else begin
          len = $urandom_range(16, 255);
        end
        count = (len > 15) ? 15 : len;
        given = (pick < 18 && count > 0) ? $urandom_range(0, count - 1) : count;
        send_start(1'($urandom), 1'($urandom), 1'($urandom), 8'(len));
        for (int i = 0; i < given; i++) begin
          send_payload(8'($urandom));
        end
        sent += 1 + given;
        left_open = (given < count);
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req++;
    for (int f = 0; f < 8; f++) begin
      send_start(1'($urandom), 1'b1, 1'($urandom), 8'd2);
      send_payload(8'($urandom));
      send_payload(8'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_frames();
    test_random_traffic(40, 0, 0);
    test_random_traffic(40, 87, 0);
    test_random_traffic(40, 0, 87);
    test_random_traffic(40, 31, 31);
    test_backpressure();

    repeat (16) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      note_fault($sformatf("%0d expected bytes never arrived.", pending_bytes.size()));
    end
    $display("Accepted %0d items (%0d dropped with no frame open),", items_taken,
             dropped_count);
    $display("checked %0d bytes in %0d frames; input was held off for %0d cycles.",
             bytes_seen, frames_seen, input_stalls);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
